// File: hdl/tcpopt_pkg.sv
// Package with the option kind codes, record codes and record helpers of the TCP option parser.
`timescale 1ns / 1ps

package tcpopt_pkg;

    localparam logic [7:0] KIND_EOL   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_MSS   = 8'd2;
    localparam logic [7:0] KIND_WS    = 8'd3;
    localparam logic [7:0] KIND_SACKP = 8'd4;
    localparam logic [7:0] KIND_TS    = 8'd8;

    localparam logic [7:0] LEN_MSS   = 8'd4;
    localparam logic [7:0] LEN_TS    = 8'd10;
    localparam logic [7:0] LEN_WS    = 8'd3;
    localparam logic [7:0] LEN_SACKP = 8'd2;
    localparam logic [7:0] LEN_MIN   = 8'd2;
    localparam logic [7:0] LEN_NONE  = 8'd0;

    localparam logic [3:0] TS_LOW_BYTES = 4'd4;
    localparam logic [3:0] BODY_MAX     = 4'd15;

    typedef enum logic [2:0] {
        REC_NOP   = 3'd0,
        REC_MSS   = 3'd1,
        REC_TS    = 3'd2,
        REC_WS    = 3'd3,
        REC_SACKP = 3'd4,
        REC_OTHER = 3'd5,
        REC_EOL   = 3'd6,
        REC_ERR   = 3'd7
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [31:0] first;
        logic [31:0] second;
        logic        fin;
    } rec_t;

    function automatic logic [7:0] expected_len(input logic [7:0] kind);
        logic [7:0] len;
        unique case (kind)
            KIND_MSS:   len = LEN_MSS;
            KIND_TS:    len = LEN_TS;
            KIND_WS:    len = LEN_WS;
            KIND_SACKP: len = LEN_SACKP;
            default:    len = LEN_NONE;
        endcase
        return len;
    endfunction

    function automatic rec_t make_rec(input rec_kind_t kind, input logic [31:0] first,
                                      input logic [31:0] second, input logic fin);
        rec_t r;
        r.kind   = kind;
        r.first  = first;
        r.second = second;
        r.fin    = fin;
        return r;
    endfunction

    function automatic rec_t complete_rec(input logic [7:0] kind, input logic [31:0] low,
                                          input logic [31:0] high, input logic fin);
        rec_t r;
        unique case (kind)
            KIND_MSS:   r = make_rec(REC_MSS, {16'd0, low[15:0]}, 32'd0, fin);
            KIND_TS:    r = make_rec(REC_TS, low, high, fin);
            KIND_WS:    r = make_rec(REC_WS, {24'd0, low[7:0]}, 32'd0, fin);
            KIND_SACKP: r = make_rec(REC_SACKP, 32'd0, 32'd0, fin);
            default:    r = make_rec(REC_OTHER, {24'd0, kind}, 32'd0, fin);
        endcase
        return r;
    endfunction

endpackage

// File: hdl/tcp_option_parser.sv
// Top level of the TCP option parser: byte-stream state machine with a registered record output.
`timescale 1ns / 1ps

// The parser takes one option-area byte per beat, with area_end on the final byte, and
// returns at most one record per accepted byte, through the registered output. A byte can
// be accepted in every cycle while byte_stall is low. The record output has a register and
// a one-entry skid stage, so bytes keep flowing while a record waits, and byte_stall rises
// only when both hold a record.
module tcp_option_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  option_byte,
    input  logic        area_end,
    output logic        rec_valid,
    input  logic        rec_stall,
    output logic [2:0]  record_kind,
    output logic [31:0] first_value,
    output logic [31:0] second_value,
    output logic        final_record
);

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_IGNORE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         kind_reg, kind_next;
    logic [7:0]         left_reg, left_next;
    logic [31:0]        low_reg, low_next;
    logic [31:0]        high_reg, high_next;
    logic [3:0]         index_reg, index_next;

    tcpopt_pkg::rec_t   rec_next;
    logic               produce;
    tcpopt_pkg::rec_t   out_reg;
    logic               out_valid_reg;
    tcpopt_pkg::rec_t   skid_reg;
    logic               skid_valid_reg;
    logic               accept;
    logic               out_free;
    logic [7:0]         want;

    assign byte_stall   = skid_valid_reg;
    assign accept       = byte_valid && !skid_valid_reg;
    assign out_free     = !out_valid_reg || !rec_stall;

    assign rec_valid    = out_valid_reg;
    assign record_kind  = out_reg.kind;
    assign first_value  = out_reg.first;
    assign second_value = out_reg.second;
    assign final_record = out_reg.fin;

    assign want = tcpopt_pkg::expected_len(kind_reg);

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        index_next = index_reg;
        produce    = 1'b0;
        rec_next   = tcpopt_pkg::make_rec(tcpopt_pkg::REC_ERR, 32'd0, 32'd0, 1'b1);
        unique case (phase_reg)
            PH_KIND:
            begin
                if (option_byte == tcpopt_pkg::KIND_EOL)
                begin
                    produce    = 1'b1;
                    rec_next   = tcpopt_pkg::make_rec(tcpopt_pkg::REC_EOL, 32'd0, 32'd0, 1'b1);
                    phase_next = area_end ? PH_KIND : PH_IGNORE;
                end
                else if (option_byte == tcpopt_pkg::KIND_NOP)
                begin
                    produce  = 1'b1;
                    rec_next = tcpopt_pkg::make_rec(tcpopt_pkg::REC_NOP, 32'd0, 32'd0,
                                                    area_end);
                end
                else
                begin
                    kind_next  = option_byte;
                    low_next   = 32'd0;
                    high_next  = 32'd0;
                    index_next = 4'd0;
                    left_next  = 8'd0;
                    if (area_end)
                    begin
                        produce = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                if (option_byte < tcpopt_pkg::LEN_MIN ||
                    (want != tcpopt_pkg::LEN_NONE && option_byte != want))
                begin
                    produce    = 1'b1;
                    phase_next = area_end ? PH_KIND : PH_IGNORE;
                end
                else if (option_byte == tcpopt_pkg::LEN_MIN)
                begin
                    produce    = 1'b1;
                    rec_next   = tcpopt_pkg::complete_rec(kind_reg, low_reg, high_reg, area_end);
                    phase_next = PH_KIND;
                end
                else
                begin
                    left_next = option_byte - tcpopt_pkg::LEN_MIN;
                    if (area_end)
                    begin
                        produce    = 1'b1;
                        phase_next = PH_KIND;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (kind_reg == tcpopt_pkg::KIND_TS)
                begin
                    if (index_reg < tcpopt_pkg::TS_LOW_BYTES)
                    begin
                        low_next = {low_reg[23:0], option_byte};
                    end
                    else
                    begin
                        high_next = {high_reg[23:0], option_byte};
                    end
                end
                else if (kind_reg == tcpopt_pkg::KIND_MSS || kind_reg == tcpopt_pkg::KIND_WS)
                begin
                    low_next = {low_reg[23:0], option_byte};
                end
                if (index_reg < tcpopt_pkg::BODY_MAX)
                begin
                    index_next = index_reg + 4'd1;
                end
                if (left_reg != 8'd0)
                begin
                    left_next = left_reg - 8'd1;
                end
                if (left_next == 8'd0)
                begin
                    produce    = 1'b1;
                    rec_next   = tcpopt_pkg::complete_rec(kind_reg, low_next, high_next,
                                                          area_end);
                    phase_next = PH_KIND;
                end
                else if (area_end)
                begin
                    produce    = 1'b1;
                    phase_next = PH_KIND;
                end
            end
            PH_IGNORE:
            begin
                if (area_end)
                begin
                    phase_next = PH_KIND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KIND;
            kind_reg       <= 8'd0;
            left_reg       <= 8'd0;
            low_reg        <= 32'd0;
            high_reg       <= 32'd0;
            index_reg      <= 4'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                left_reg  <= left_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
                index_reg <= index_next;
            end
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else if (accept && produce)
                begin
                    out_reg       <= rec_next;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (accept && produce)
            begin
                skid_reg       <= rec_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The skid stage is only filled behind a held output record.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid record present without an output record");

    // A body phase always has body bytes still to come.
    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (left_reg != 8'd0))
        else $error("body phase with no bytes left");

    // The end of the area always rearms the parser from the ignore phase.
    a_ignore_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && area_end && phase_reg == PH_IGNORE) |=> (phase_reg == PH_KIND))
        else $error("area end did not rearm the parser");

    // End-of-list and error records close the area.
    a_final_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == tcpopt_pkg::REC_EOL ||
                           out_reg.kind == tcpopt_pkg::REC_ERR)) |-> out_reg.fin)
        else $error("end-of-list or error record without final flag");
`endif

endmodule
